// ===== src/hrp_pkg.sv =====
`timescale 1ns / 1ps

package hrp_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int ACC_EXT_BITS = OFFSET_BITS + 4;

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// index of the last character of both keywords
	localparam logic [2:0] WORD_LAST = 3'd5;
	// characters of the range keyword below this index match without regard to case
	localparam logic [2:0] FOLD_LIMIT = 3'd5;

	typedef enum logic [7:0] {
		PH_LINE   = 8'b0000_0001,
		PH_SKIP   = 8'b0000_0010,
		PH_SPACES = 8'b0000_0100,
		PH_BYTES  = 8'b0000_1000,
		PH_START  = 8'b0001_0000,
		PH_DASH   = 8'b0010_0000,
		PH_END    = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		OC_UNDECIDED = 2'd0,
		OC_REJECTED  = 2'd1,
		OC_PARSED    = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [7:0]  request_byte;
		logic [31:0] body_length;
		logic        end_of_request;
	} req_item_t;

	typedef struct packed {
		logic        range_valid;
		logic [31:0] first_offset;
		logic [31:0] last_offset;
	} rsp_item_t;

	typedef struct packed {
		phase_t                 phase;
		logic [2:0]             match_position;
		logic [OFFSET_BITS-1:0] start_acc;
		logic [OFFSET_BITS-1:0] end_acc;
		logic                   end_given;
		outcome_t               outcome;
	} scan_state_t;

	function automatic logic [7:0] range_char(logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0: ch = 8'h72;
			3'd1: ch = 8'h61;
			3'd2: ch = 8'h6E;
			3'd3: ch = 8'h67;
			3'd4: ch = 8'h65;
			3'd5: ch = 8'h3A;
			default: ch = 8'h3A;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] bytes_char(logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0: ch = 8'h62;
			3'd1: ch = 8'h79;
			3'd2: ch = 8'h74;
			3'd3: ch = 8'h65;
			3'd4: ch = 8'h73;
			3'd5: ch = 8'h3D;
			default: ch = 8'h3D;
		endcase
		return ch;
	endfunction

	// acc * 10 + digit, held at the top value on overflow
	function automatic logic [OFFSET_BITS-1:0] push_digit(logic [OFFSET_BITS-1:0] acc,
			logic [3:0] digit);
		logic [ACC_EXT_BITS-1:0] wide;
		logic [ACC_EXT_BITS-1:0] sum;
		wide = ACC_EXT_BITS'(acc);
		sum = (wide << 3) + (wide << 1) + ACC_EXT_BITS'(digit);
		if (sum > ACC_EXT_BITS'(OFFSET_MAX)) begin
			return OFFSET_MAX;
		end
		return sum[OFFSET_BITS-1:0];
	endfunction

	function automatic scan_state_t scan_reset_state();
		scan_state_t st;
		st.phase = PH_LINE;
		st.match_position = 3'd0;
		st.start_acc = '0;
		st.end_acc = '0;
		st.end_given = 1'b0;
		st.outcome = OC_UNDECIDED;
		return st;
	endfunction

endpackage

// ===== src/http_range_header_parser.sv =====
`timescale 1ns / 1ps

// Byte-range header parser. Request bytes enter one per cycle on req, with the
// body length alongside; the byte flagged end_of_request yields one result,
// offered on rsp once it has passed the input register and the result register,
// and every other byte yields none. The scan state update and the shared
// multiply-by-ten add sit in the combinational logic between the input register
// and the result register, so a byte is taken in every cycle; only the final byte
// of a request waits, while the previous result is still held by rsp_stall. There
// is no start-up sweep: the block takes bytes from the first cycle after reset.
module http_range_header_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  hrp_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output hrp_pkg::rsp_item_t rsp
);

	logic                 valid_s1;
	hrp_pkg::req_item_t   item_s1;
	logic                 rsp_valid_s2;
	hrp_pkg::rsp_item_t   rsp_s2;
	logic                 advance;
	hrp_pkg::scan_state_t post;
	hrp_pkg::rsp_item_t   result;

	// an item with no result never waits on the output side
	assign advance = valid_s1 && (!item_s1.end_of_request || !rsp_valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	hrp_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.request_byte   (item_s1.request_byte),
		.end_of_request (item_s1.end_of_request),
		.post           (post)
	);

	hrp_resolve u_resolve (
		.post        (post),
		.body_length (item_s1.body_length),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance && item_s1.end_of_request) begin
			rsp_valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_request) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp = rsp_s2;

endmodule

// ===== src/hrp_scan.sv =====
`timescale 1ns / 1ps

module hrp_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          request_byte,
	input  logic                end_of_request,
	output hrp_pkg::scan_state_t post
);

	hrp_pkg::scan_state_t st_q;
	hrp_pkg::scan_state_t nxt;

	logic       is_digit;
	logic [3:0] digit;
	logic [7:0] folded;
	logic [2:0] pos_inc;
	logic [hrp_pkg::OFFSET_BITS-1:0] acc_sel;
	logic [hrp_pkg::OFFSET_BITS-1:0] acc_new;

	assign is_digit = (request_byte >= hrp_pkg::CH_ZERO) && (request_byte <= hrp_pkg::CH_NINE);
	assign digit = 4'(request_byte - hrp_pkg::CH_ZERO);
	assign pos_inc = 3'(st_q.match_position + 3'd1);

	always_comb begin
		if (st_q.match_position < hrp_pkg::FOLD_LIMIT
				&& request_byte >= hrp_pkg::CH_UPPER_A
				&& request_byte <= hrp_pkg::CH_UPPER_Z) begin
			folded = request_byte | hrp_pkg::CASE_BIT;
		end else begin
			folded = request_byte;
		end
	end

	// one shared multiply-by-ten unit for both numbers
	assign acc_sel = (st_q.phase == hrp_pkg::PH_START) ? st_q.start_acc : st_q.end_acc;
	assign acc_new = hrp_pkg::push_digit(acc_sel, digit);

	always_comb begin
		nxt = st_q;
		unique case (st_q.phase) inside
			hrp_pkg::PH_LINE: begin
				if (request_byte == hrp_pkg::CH_NUL) begin
					nxt.phase = hrp_pkg::PH_DONE;
					nxt.outcome = hrp_pkg::OC_REJECTED;
				end else if (folded == hrp_pkg::range_char(st_q.match_position)) begin
					if (st_q.match_position == hrp_pkg::WORD_LAST) begin
						nxt.match_position = 3'd0;
						nxt.phase = hrp_pkg::PH_SPACES;
					end else begin
						nxt.match_position = pos_inc;
					end
				end else if (request_byte == hrp_pkg::CH_LF) begin
					nxt.match_position = 3'd0;
				end else begin
					nxt.match_position = 3'd0;
					nxt.phase = hrp_pkg::PH_SKIP;
				end
			end
			hrp_pkg::PH_SKIP: begin
				if (request_byte == hrp_pkg::CH_NUL) begin
					nxt.phase = hrp_pkg::PH_DONE;
					nxt.outcome = hrp_pkg::OC_REJECTED;
				end else if (request_byte == hrp_pkg::CH_LF) begin
					nxt.match_position = 3'd0;
					nxt.phase = hrp_pkg::PH_LINE;
				end
			end
			hrp_pkg::PH_SPACES: begin
				if (request_byte != hrp_pkg::CH_SPACE) begin
					// first non-space is the first keyword character
					if (request_byte != hrp_pkg::bytes_char(3'd0)) begin
						nxt.phase = hrp_pkg::PH_DONE;
						nxt.outcome = hrp_pkg::OC_REJECTED;
					end else begin
						nxt.match_position = 3'd1;
						nxt.phase = hrp_pkg::PH_BYTES;
					end
				end
			end
			hrp_pkg::PH_BYTES: begin
				if (request_byte != hrp_pkg::bytes_char(st_q.match_position)) begin
					nxt.phase = hrp_pkg::PH_DONE;
					nxt.outcome = hrp_pkg::OC_REJECTED;
				end else if (st_q.match_position == hrp_pkg::WORD_LAST) begin
					nxt.match_position = 3'd0;
					nxt.phase = hrp_pkg::PH_START;
				end else begin
					nxt.match_position = pos_inc;
				end
			end
			hrp_pkg::PH_START: begin
				if (is_digit) begin
					nxt.start_acc = acc_new;
				end else if (request_byte == hrp_pkg::CH_DASH) begin
					nxt.phase = hrp_pkg::PH_DASH;
				end else begin
					nxt.phase = hrp_pkg::PH_DONE;
					nxt.outcome = hrp_pkg::OC_PARSED;
				end
			end
			hrp_pkg::PH_DASH, hrp_pkg::PH_END: begin
				if (is_digit) begin
					nxt.end_acc = acc_new;
					nxt.end_given = 1'b1;
					nxt.phase = hrp_pkg::PH_END;
				end else begin
					nxt.phase = hrp_pkg::PH_DONE;
					nxt.outcome = hrp_pkg::OC_PARSED;
				end
			end
			hrp_pkg::PH_DONE: begin
				nxt = st_q;
			end
			default: begin
				nxt = st_q;
			end
		endcase
	end

	assign post = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hrp_pkg::scan_reset_state();
		end else if (step) begin
			// each request starts afresh after its last byte
			if (end_of_request) begin
				st_q <= hrp_pkg::scan_reset_state();
			end else begin
				st_q <= nxt;
			end
		end
	end

endmodule

// ===== src/hrp_resolve.sv =====
`timescale 1ns / 1ps

module hrp_resolve (
	input  hrp_pkg::scan_state_t post,
	input  logic [31:0]          body_length,
	output hrp_pkg::rsp_item_t   result
);

	logic [hrp_pkg::OFFSET_BITS-1:0] len;
	logic [hrp_pkg::OFFSET_BITS-1:0] whole_last;
	logic [hrp_pkg::OFFSET_BITS-1:0] end_raw;
	logic [hrp_pkg::OFFSET_BITS-1:0] end_clamped;
	logic                            parsed;
	logic                            valid;

	assign len = hrp_pkg::OFFSET_BITS'(body_length);
	assign whole_last = (len != '0) ? len - hrp_pkg::OFFSET_BITS'(1) : '0;

	// a scan still inside the numbers counts as parsed
	assign parsed = (post.phase == hrp_pkg::PH_DONE && post.outcome == hrp_pkg::OC_PARSED)
		|| post.phase == hrp_pkg::PH_START || post.phase == hrp_pkg::PH_DASH
		|| post.phase == hrp_pkg::PH_END;

	assign end_raw = post.end_given ? post.end_acc : whole_last;
	assign end_clamped = (end_raw >= len) ? whole_last : end_raw;
	assign valid = parsed && (post.start_acc < len) && (end_clamped >= post.start_acc);

	assign result.range_valid = valid;
	assign result.first_offset = valid ? 32'(post.start_acc) : 32'd0;
	assign result.last_offset = valid ? 32'(end_clamped) : 32'(whole_last);

endmodule

// ===== src/hrp_checker.sv =====
`timescale 1ns / 1ps

module hrp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input hrp_pkg::rsp_item_t rsp
);

	// a held result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("result item changed while stalled");

	// input only waits behind a result that is being held
	a_req_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled with no held result");

	// a valid range never runs backwards
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.range_valid |-> rsp.first_offset <= rsp.last_offset)
		else $error("valid range with first offset past last offset");

	// an invalid range sends the body from its start
	a_invalid_first: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.range_valid |-> rsp.first_offset == 32'd0)
		else $error("invalid range with nonzero first offset");

endmodule

bind http_range_header_parser hrp_checker u_hrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int RESULT_LATENCY = 2;
	localparam int STALL_LIMIT = 1000;
	localparam logic [47:0] RANGE_WORD = "range:";
	localparam logic [47:0] BYTES_WORD = "bytes=";

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	hrp_pkg::req_item_t  req;
	logic                rsp_valid;
	logic                rsp_stall;
	hrp_pkg::rsp_item_t  rsp;

	// scan state of the expected behaviour
	hrp_pkg::phase_t     scan_ph;
	logic [2:0]          key_pos;
	logic [31:0]         first_acc;
	logic [31:0]         last_acc;
	logic                last_seen;
	hrp_pkg::outcome_t   verdict;

	hrp_pkg::rsp_item_t  expected_ranges[$];
	logic [7:0]          request_text[$];
	int                  fail_count = 0;
	int                  bytes_sent = 0;
	bit                  steady = 1'b0;

	http_range_header_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic logic [7:0] word_char(logic [47:0] word, int p);
		return word[47 - 8 * p -: 8];
	endfunction

	function automatic logic is_digit(logic [7:0] ch);
		return ch >= hrp_pkg::CH_ZERO && ch <= hrp_pkg::CH_NINE;
	endfunction

	// decimal shift-in, held at the top value once it overflows
	function automatic logic [31:0] next_decimal(logic [31:0] acc, logic [7:0] ch);
		logic [35:0] sum;
		sum = {4'b0, acc} * 36'd10 + {28'b0, ch - hrp_pkg::CH_ZERO};
		return (sum > {4'b0, hrp_pkg::OFFSET_MAX}) ? hrp_pkg::OFFSET_MAX : sum[31:0];
	endfunction

	task automatic clear_scan();
		scan_ph = hrp_pkg::PH_LINE;
		key_pos = 3'd0;
		first_acc = '0;
		last_acc = '0;
		last_seen = 1'b0;
		verdict = hrp_pkg::OC_UNDECIDED;
	endtask

	task automatic close_scan(input hrp_pkg::outcome_t oc);
		verdict = oc;
		scan_ph = hrp_pkg::PH_DONE;
	endtask

	task automatic parse_request_byte(input hrp_pkg::req_item_t it);
		logic [7:0]         b;
		logic [7:0]         c;
		int                 p;
		logic [31:0]        whole_last;
		logic [31:0]        e;
		hrp_pkg::rsp_item_t res;
		b = it.request_byte;
		case (scan_ph) inside
			hrp_pkg::PH_LINE: begin
				p = (key_pos < 3'd6) ? int'(key_pos) : 0;
				c = (p < int'(hrp_pkg::FOLD_LIMIT) && b >= hrp_pkg::CH_UPPER_A
					&& b <= hrp_pkg::CH_UPPER_Z) ? (b | hrp_pkg::CASE_BIT) : b;
				if (b == hrp_pkg::CH_NUL) begin
					close_scan(hrp_pkg::OC_REJECTED);
				end else if (c == word_char(RANGE_WORD, p)) begin
					if (p == int'(hrp_pkg::WORD_LAST)) begin
						key_pos = 3'd0;
						scan_ph = hrp_pkg::PH_SPACES;
					end else begin
						key_pos = 3'(p + 1);
					end
				end else if (b == hrp_pkg::CH_LF) begin
					key_pos = 3'd0;
				end else begin
					key_pos = 3'd0;
					scan_ph = hrp_pkg::PH_SKIP;
				end
			end
			hrp_pkg::PH_SKIP: begin
				if (b == hrp_pkg::CH_NUL) begin
					close_scan(hrp_pkg::OC_REJECTED);
				end else if (b == hrp_pkg::CH_LF) begin
					key_pos = 3'd0;
					scan_ph = hrp_pkg::PH_LINE;
				end
			end
			hrp_pkg::PH_SPACES, hrp_pkg::PH_BYTES: begin
				if (scan_ph != hrp_pkg::PH_SPACES || b != hrp_pkg::CH_SPACE) begin
					if (scan_ph == hrp_pkg::PH_SPACES) begin
						key_pos = 3'd0;
						scan_ph = hrp_pkg::PH_BYTES;
					end
					p = (key_pos < 3'd6) ? int'(key_pos) : 0;
					if (b != word_char(BYTES_WORD, p)) begin
						close_scan(hrp_pkg::OC_REJECTED);
					end else if (p == int'(hrp_pkg::WORD_LAST)) begin
						key_pos = 3'd0;
						scan_ph = hrp_pkg::PH_START;
					end else begin
						key_pos = 3'(p + 1);
					end
				end
			end
			hrp_pkg::PH_START: begin
				if (is_digit(b)) begin
					first_acc = next_decimal(first_acc, b);
				end else if (b == hrp_pkg::CH_DASH) begin
					scan_ph = hrp_pkg::PH_DASH;
				end else begin
					close_scan(hrp_pkg::OC_PARSED);
				end
			end
			hrp_pkg::PH_DASH, hrp_pkg::PH_END: begin
				if (is_digit(b)) begin
					last_acc = next_decimal(last_acc, b);
					last_seen = 1'b1;
					scan_ph = hrp_pkg::PH_END;
				end else begin
					close_scan(hrp_pkg::OC_PARSED);
				end
			end
			default: ;
		endcase

		if (it.end_of_request) begin
			// a request cut off inside the numbers keeps what was parsed
			if (verdict == hrp_pkg::OC_UNDECIDED &&
					(scan_ph == hrp_pkg::PH_START || scan_ph == hrp_pkg::PH_DASH
					|| scan_ph == hrp_pkg::PH_END)) begin
				verdict = hrp_pkg::OC_PARSED;
			end
			whole_last = (it.body_length != '0) ? it.body_length - 32'd1 : '0;
			res.range_valid = 1'b0;
			res.first_offset = '0;
			res.last_offset = whole_last;
			e = last_seen ? last_acc : whole_last;
			if (verdict == hrp_pkg::OC_PARSED && first_acc < it.body_length) begin
				if (e >= it.body_length) begin
					e = it.body_length - 32'd1;
				end
				if (e >= first_acc) begin
					res.range_valid = 1'b1;
					res.first_offset = first_acc;
					res.last_offset = e;
				end
			end
			expected_ranges.push_back(res);
			clear_scan();
		end
	endtask

	task automatic send_byte(input hrp_pkg::req_item_t it);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		parse_request_byte(it);
		bytes_sent++;
	endtask

	task automatic send_request(input logic [31:0] len);
		hrp_pkg::req_item_t it;
		int                 i;
		if (request_text.size() == 0) begin
			request_text.push_back(8'($urandom_range(0, 255)));
		end
		for (i = 0; i < request_text.size(); i++) begin
			it.request_byte = request_text[i];
			it.body_length = len;
			it.end_of_request = (i == request_text.size() - 1);
			send_byte(it);
		end
		request_text.delete();
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_ranges.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			request_text.push_back(s[i]);
		end
	endtask

	task automatic add_long_digits();
		repeat ($urandom_range(10, 13))
			request_text.push_back(8'(hrp_pkg::CH_ZERO + $urandom_range(0, 9)));
	endtask

	task automatic add_junk_line();
		// near miss on the header name now and then
		if ($urandom_range(0, 3) == 0) begin
			put_text("Rang");
		end
		repeat ($urandom_range(0, 8)) request_text.push_back(8'($urandom_range(32, 126)));
		request_text.push_back(hrp_pkg::CH_LF);
	endtask

	task automatic add_number(input logic [31:0] len);
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: ;
			1: add_long_digits();
			default: begin
				case ($urandom_range(0, 4))
					0: v = $urandom;
					1: v = len - 32'($urandom_range(0, 3));
					2: v = len + 32'($urandom_range(0, 2));
					default: v = 32'($urandom_range(0, 40));
				endcase
				put_text($sformatf("%0d", v));
			end
		endcase
	endtask

	function automatic logic [31:0] pick_length();
		logic [31:0] len;
		case ($urandom_range(0, 7)) inside
			0: len = '0;
			1: len = hrp_pkg::OFFSET_MAX;
			2, 3: len = $urandom;
			default: len = 32'($urandom_range(1, 60));
		endcase
		return len;
	endfunction

	task automatic add_range_request(input logic [31:0] len);
		int         k;
		int         flip;
		logic [7:0] ch;
		repeat ($urandom_range(0, 2)) add_junk_line();
		for (k = 0; k < 5; k++) begin
			ch = word_char(RANGE_WORD, k);
			if ($urandom_range(0, 1) == 1) begin
				ch = ch & ~hrp_pkg::CASE_BIT;
			end
			request_text.push_back(ch);
		end
		ch = word_char(RANGE_WORD, 5);
		request_text.push_back(($urandom_range(0, 19) == 0) ? (ch ^ 8'h01) : ch);
		repeat ($urandom_range(0, 3)) request_text.push_back(hrp_pkg::CH_SPACE);
		flip = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 5) : -1;
		for (k = 0; k < 6; k++) begin
			ch = word_char(BYTES_WORD, k);
			if (k == flip) begin
				ch = ch ^ 8'($urandom_range(1, 255));
			end
			request_text.push_back(ch);
		end
		add_number(len);
		if ($urandom_range(0, 7) != 0) begin
			request_text.push_back(hrp_pkg::CH_DASH);
			add_number(len);
		end
		case ($urandom_range(0, 4))
			0: add_junk_line();
			1: begin
				request_text.push_back(hrp_pkg::CH_NUL);
				request_text.push_back(8'($urandom_range(0, 255)));
			end
			2: request_text.push_back(8'($urandom_range(0, 255)));
			default: ;
		endcase
		// cut the request short now and then
		if ($urandom_range(0, 9) == 0) begin
			k = $urandom_range(1, request_text.size());
			while (request_text.size() > k) void'(request_text.pop_back());
		end
	endtask

	task automatic add_noise_request();
		repeat ($urandom_range(1, 20)) begin
			case ($urandom_range(0, 7))
				0: request_text.push_back(hrp_pkg::CH_NUL);
				1: request_text.push_back(hrp_pkg::CH_LF);
				default: request_text.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic send_random_request();
		logic [31:0] len;
		len = pick_length();
		if ($urandom_range(0, 4) == 0) begin
			add_noise_request();
		end else begin
			add_range_request(len);
		end
		send_request(len);
	endtask

	task automatic test_directed_ranges();
		put_text("Range: bytes=0-99");
		send_request(32'd1000);
		put_text("rAnGe:bytes=5-");
		send_request(32'd10);
		put_text("RANGE:   bytes=-5");
		send_request(32'd100);
		put_text("Range: bytes=200-300");
		send_request(32'd100);
		put_text("Range: bytes=10-5000");
		send_request(32'd100);
		put_text("Range: bytes=50-10");
		send_request(32'd100);
		put_text("Range: bytes=5");
		send_request(32'd10);
		put_text("Range: bytes=3-x\nRange: bytes=1-1");
		send_request(32'd10);
		put_text("Range: Bytes=1-2\nRange: bytes=1-2");
		send_request(32'd10);
		put_text("Host: a\nRange: bytes=1-2");
		send_request(32'd10);
		// zero byte inside the numbers keeps the start
		put_text("Range: bytes=12");
		request_text.push_back(hrp_pkg::CH_NUL);
		put_text("-99");
		send_request(32'd50);
		put_text("Range: by");
		request_text.push_back(hrp_pkg::CH_NUL);
		put_text("tes=1");
		send_request(32'd50);
		put_text("Range: byt");
		send_request(32'd50);
		put_text("Range: bytes=0-0");
		send_request(32'd0);
		put_text("Range: bytes=0-99999999999");
		send_request(hrp_pkg::OFFSET_MAX);
		put_text("Range: bytes=99999999999-");
		send_request(hrp_pkg::OFFSET_MAX);
		put_text("Range: bytes=4294967294-");
		send_request(hrp_pkg::OFFSET_MAX);
		request_text.push_back(hrp_pkg::CH_NUL);
		send_request(32'd7);
		request_text.push_back(8'hFF);
		send_request(32'h8000_0000);
	endtask

	task automatic test_random_requests();
		int n;
		n = 0;
		while (bytes_sent < 1200) begin
			send_random_request();
			n++;
			if (n % 9 == 0) begin
				hold_until_drained();
			end
		end
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		while (bytes_sent < 1480) send_random_request();
		steady = 1'b0;
	endtask

	task automatic test_drained_pauses();
		repeat (4) begin
			send_random_request();
			hold_until_drained();
		end
	endtask

	initial begin : result_checker
		hrp_pkg::rsp_item_t want;
		int                 hold;
		rsp_stall = 1'b0;
		forever begin
			hold = draw_gap();
			@(negedge clk);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (expected_ranges.size() == 0) begin
				$display("%0t: unexpected result, expected none, got valid=%0d first=%h last=%h",
					$time, rsp.range_valid, rsp.first_offset, rsp.last_offset);
				fail_count++;
			end else begin
				want = expected_ranges.pop_front();
				if (rsp.range_valid !== want.range_valid) begin
					$display("%0t: range_valid expected %0d, got %0d",
						$time, want.range_valid, rsp.range_valid);
					fail_count++;
				end
				if (rsp.first_offset !== want.first_offset) begin
					$display("%0t: first_offset expected %h, got %h",
						$time, want.first_offset, rsp.first_offset);
					fail_count++;
				end
				if (rsp.last_offset !== want.last_offset) begin
					$display("%0t: last_offset expected %h, got %h",
						$time, want.last_offset, rsp.last_offset);
					fail_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		clear_scan();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_ranges();
		test_random_requests();
		test_back_to_back();
		test_drained_pauses();

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/hrp_pkg.sv
src/hrp_scan.sv
src/hrp_resolve.sv
src/http_range_header_parser.sv
src/hrp_checker.sv
sim/testbench.sv
